// File: hdl/pcx_pkg.sv
// Shared types and constants for the plane crossing trigger bank.
package pcx_pkg;

    // Default sizes of the entry table and of one coordinate.
    localparam int MAX_SWITCHES_DEF = 16;
    localparam int COORD_BITS_DEF   = 32;

    // Operand width of the shared multiplier: a coordinate difference or a 32-bit square.
    localparam int MUL_W = 33;
    localparam int SH_W  = 6;

    // Request kinds.
    localparam logic [1:0] REQ_UPDATE  = 2'd0;
    localparam logic [1:0] REQ_VECTOR  = 2'd1;
    localparam logic [1:0] REQ_CAMERAS = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_HYST   = 1'b1;

    // Side codes held per entry.
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_PLUS  = 2'd1;
    localparam logic [1:0] SIDE_MINUS = 2'd2;

    localparam logic [15:0] HYST_RESET = 16'd7864;
    localparam logic [8:0]  CAM_NONE   = 9'h1FF;

    // Command from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic            start;
        logic            clear;
        logic            sub;
        logic [SH_W-1:0] shift;
    } t_mac_cmd;

endpackage

// File: hdl/pcx_mac.sv
// Shared signed multiply-accumulate unit with a registered product stage.
module pcx_mac import pcx_pkg::*; #(
    parameter int ACC_W = 100
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_cmd                i_cmd,
    input  logic signed [MUL_W-1:0] i_a,
    input  logic signed [MUL_W-1:0] i_b,
    output logic signed [ACC_W-1:0] o_acc
);

    t_mac_cmd                  r_cmd;
    logic signed [2*MUL_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   term;

    // The product is sign-extended, then weighted by the requested power of two.
    assign term  = ACC_W'(r_prod) <<< r_cmd.shift;
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
        end else begin
            r_cmd <= i_cmd;
        end
        r_prod <= i_a * i_b;
        if (r_cmd.start) begin
            if (r_cmd.clear) begin
                r_acc <= r_cmd.sub ? -term : term;
            end else begin
                r_acc <= r_cmd.sub ? r_acc - term : r_acc + term;
            end
        end
    end

endmodule

// File: hdl/plane_crossing_trigger_bank.sv
// Top level of the plane crossing trigger bank: sequencer, entry tables and stream ports.
// A write request stores its three words before it answers; an update walks the active
// entries, and one whose thinnest column has zero length skips the dot product.
// One request at a time; the single multiply-accumulate unit serves every square, dot
// product term and threshold product in turn. Reset (synchronous, active low) clears all
// sides, the primed flag and the active count, and sets the hysteresis to its default;
// the coordinate and camera tables are not cleared and must be written before use.
module plane_crossing_trigger_bank import pcx_pkg::*; #(
    parameter int MAX_SWITCHES = MAX_SWITCHES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: entry_index[3:0], vec_x[35:4], vec_y[67:36], vec_z[99:68],
    //        camera_a[108:100], camera_b[117:109], zero fill up to bit 119
    input  logic [119:0] i_s_tdata,
    // tuser: req_type[1:0], vector_select[3:2]
    input  logic [3:0]   i_s_tuser,
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: camera_index[8:0], zero fill up to bit 15
    output logic [15:0]  o_m_tdata,
    // Configuration write channel.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam int W     = COORD_BITS;
    localparam int RW    = W + 1;
    localparam int LW    = 2 * W;
    localparam int DT    = W + 16;          // |D| at or above 2^DT always passes
    localparam int HB    = (DT + 1) / 2;    // low half of |D| for the squaring
    localparam int ACC_W = 2 * W + 36;
    localparam int DEPTH = MAX_SWITCHES * 12;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = (MAX_SWITCHES > 1) ? $clog2(MAX_SWITCHES) : 1;
    localparam int CW    = $clog2(MAX_SWITCHES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_WR, S_HH, S_HHW, S_HHC,
        S_LEN_RD, S_LEN_MUL, S_LEN_WAIT, S_LEN_CMP, S_SEL,
        S_DOT_RC, S_DOT_RA, S_DOT_MUL, S_DOT_WAIT, S_DOT_CHK,
        S_SQ0, S_SQ1, S_SQ2, S_RL, S_RH, S_BWAIT, S_BCHK,
        S_SIDE, S_NEXT, S_DONE
    } t_state;

    t_state                  r_state;
    logic [4:0]              r_active;
    logic [15:0]             r_hyst;
    logic [W-1:0]            r_vec [3];
    logic [3:0]              r_widx;
    logic [1:0]              r_wsel;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           r_i;
    logic [1:0]              r_k;
    logic [1:0]              r_c;
    logic [1:0]              r_thin;
    logic [LW-1:0]           r_best;
    logic [31:0]             r_hh;
    logic [W-1:0]            r_cen;
    logic [DT-1:0]           r_mag;
    logic                    r_neg;
    logic                    r_beyond;
    logic [1:0]              r_side [MAX_SWITCHES];
    logic                    r_primed;
    logic [8:0]              r_res;
    logic                    r_ovalid;

    logic [W-1:0]            coord_mem [DEPTH];
    logic [W-1:0]            r_rdata;
    logic [17:0]             cam_mem [MAX_SWITCHES];
    logic [17:0]             r_camq;

    logic                    s_acc;
    logic [1:0]              req;
    logic [3:0]              eidx;
    logic                    in_table;
    logic [IW-1:0]           idx;
    logic [3:0]              off;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic signed [RW-1:0]    rel;
    logic [DT-HB-1:0]        mag_hi;
    logic [HB-1:0]           mag_lo;
    t_mac_cmd                mac_cmd;
    logic signed [MUL_W-1:0] mac_a;
    logic signed [MUL_W-1:0] mac_b;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-1:0]        acc_mag;
    logic [LW-1:0]           len_v;
    logic [1:0]              prev_side;
    logic [1:0]              new_side;

    // A request is taken only when the previous result has been handed on.
    assign o_s_tready  = (r_state == S_IDLE) && !r_ovalid;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign req         = i_s_tuser[1:0];
    assign eidx        = i_s_tdata[3:0];
    assign in_table    = 32'(eidx) < MAX_SWITCHES;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {7'd0, r_res};

    assign idx    = r_i[IW-1:0];
    assign rel    = RW'($signed(r_vec[r_c])) - RW'($signed(r_cen));
    assign mag_hi = r_mag[DT-1:HB];
    assign mag_lo = r_mag[HB-1:0];
    assign len_v  = acc[LW-1:0];
    assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

    // Word offset inside an entry: centre at 0..2, axis column k at 3k+3..3k+5.
    always_comb begin
        case (r_state)
            S_LEN_RD: off = 4'd3 * (4'(r_k) + 4'd1) + 4'(r_c);
            S_DOT_RA: off = 4'd3 * (4'(r_thin) + 4'd1) + 4'(r_c);
            default:  off = 4'(r_c);
        endcase
    end

    assign rd_addr = AW'(idx) * AW'(12) + AW'(off);
    assign wr_addr = AW'(r_widx) * AW'(12) + AW'(r_wsel) * AW'(3) + AW'(r_c);

    // Operand selection for the shared unit.
    always_comb begin
        mac_cmd = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (r_state)
            S_HH: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clear = 1'b1;
                mac_a = MUL_W'(r_hyst);
                mac_b = MUL_W'(r_hyst);
            end
            S_LEN_MUL: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clear = (r_c == 2'd0);
                mac_a = MUL_W'($signed(r_rdata));
                mac_b = MUL_W'($signed(r_rdata));
            end
            S_DOT_MUL: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clear = (r_c == 2'd0);
                mac_a = MUL_W'(rel);
                mac_b = MUL_W'($signed(r_rdata));
            end
            S_SQ0: begin
                mac_cmd.start = 1'b1;
                mac_cmd.clear = 1'b1;
                mac_cmd.shift = SH_W'(2 * HB);
                mac_a = MUL_W'(mag_hi);
                mac_b = MUL_W'(mag_hi);
            end
            S_SQ1: begin
                mac_cmd.start = 1'b1;
                mac_cmd.shift = SH_W'(HB + 1);
                mac_a = MUL_W'(mag_hi);
                mac_b = MUL_W'(mag_lo);
            end
            S_SQ2: begin
                mac_cmd.start = 1'b1;
                mac_a = MUL_W'(mag_lo);
                mac_b = MUL_W'(mag_lo);
            end
            S_RL: begin
                mac_cmd.start = 1'b1;
                mac_cmd.sub   = 1'b1;
                mac_a = MUL_W'(r_hh);
                mac_b = MUL_W'(r_best[W-1:0]);
            end
            S_RH: begin
                mac_cmd.start = 1'b1;
                mac_cmd.sub   = 1'b1;
                mac_cmd.shift = SH_W'(W);
                mac_a = MUL_W'(r_hh);
                mac_b = MUL_W'(r_best[LW-1:W]);
            end
            default: begin
                mac_cmd = '0;
            end
        endcase
    end

    pcx_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    // Side decision: a nonzero distance past the threshold commits the sign of D.
    always_comb begin
        case (r_side[idx])
            SIDE_PLUS:  prev_side = SIDE_PLUS;
            SIDE_MINUS: prev_side = SIDE_MINUS;
            default:    prev_side = SIDE_NONE;
        endcase
        if (r_beyond) begin
            new_side = r_neg ? SIDE_MINUS : SIDE_PLUS;
        end else begin
            new_side = prev_side;
        end
    end

    // Coordinate table: at most one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            coord_mem[wr_addr] <= r_vec[r_c];
        end
        r_rdata <= coord_mem[rd_addr];
    end

    // Camera table: camera_a in the low half, camera_b in the high half.
    always_ff @(posedge i_clk) begin
        if (s_acc && req == REQ_CAMERAS && in_table) begin
            cam_mem[IW'(eidx)] <= {i_s_tdata[117:109], i_s_tdata[108:100]};
        end
        r_camq <= cam_mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 5'd0;
            r_hyst   <= HYST_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACTIVE: r_active <= i_cfg_data[4:0];
                CFG_HYST:   r_hyst   <= i_cfg_data;
                default:    r_hyst   <= r_hyst;
            endcase
        end
    end

    // Sequencer. Each update walks the active entries one after another: three squared
    // column lengths, the thinnest column as normal, the dot product of the player offset
    // with it, and, unless the answer is already clear, D^2 - H^2 * L built in pieces.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_primed <= 1'b0;
            r_ovalid <= 1'b0;
            for (int n = 0; n < MAX_SWITCHES; n++) begin
                r_side[n] <= SIDE_NONE;
            end
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_vec[0] <= i_s_tdata[W+3:4];
                        r_vec[1] <= i_s_tdata[W+35:36];
                        r_vec[2] <= i_s_tdata[W+67:68];
                        r_widx   <= eidx;
                        r_wsel   <= i_s_tuser[3:2];
                        r_c      <= 2'd0;
                        r_res    <= CAM_NONE;
                        case (req)
                            REQ_UPDATE: begin
                                if (32'(r_active) > MAX_SWITCHES) begin
                                    r_cnt <= CW'(MAX_SWITCHES);
                                end else begin
                                    r_cnt <= CW'(r_active);
                                end
                                if (r_active == 5'd0) begin
                                    r_primed <= 1'b1;
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_state <= S_HH;
                                end
                            end
                            REQ_VECTOR: begin
                                if (in_table) begin
                                    r_state <= S_WR;
                                end else begin
                                    r_ovalid <= 1'b1;
                                end
                            end
                            REQ_RESTART: begin
                                r_primed <= 1'b0;
                                r_ovalid <= 1'b1;
                                for (int n = 0; n < MAX_SWITCHES; n++) begin
                                    r_side[n] <= SIDE_NONE;
                                end
                            end
                            default: begin
                                r_ovalid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_WR: begin
                    if (r_c == 2'd2) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_c <= r_c + 2'd1;
                    end
                end
                S_HH:  r_state <= S_HHW;
                S_HHW: r_state <= S_HHC;
                S_HHC: begin
                    r_hh    <= acc[31:0];
                    r_i     <= '0;
                    r_k     <= 2'd0;
                    r_c     <= 2'd0;
                    r_state <= S_LEN_RD;
                end
                S_LEN_RD: r_state <= S_LEN_MUL;
                S_LEN_MUL: begin
                    if (r_c == 2'd2) begin
                        r_state <= S_LEN_WAIT;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_LEN_RD;
                    end
                end
                S_LEN_WAIT: r_state <= S_LEN_CMP;
                S_LEN_CMP: begin
                    // Strict compare keeps the earlier column on a tie.
                    if (r_k == 2'd0 || len_v < r_best) begin
                        r_best <= len_v;
                        r_thin <= r_k;
                    end
                    r_c <= 2'd0;
                    if (r_k == 2'd2) begin
                        r_state <= S_SEL;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_LEN_RD;
                    end
                end
                S_SEL: begin
                    r_c     <= 2'd0;
                    r_state <= (r_best == '0) ? S_NEXT : S_DOT_RC;
                end
                S_DOT_RC: r_state <= S_DOT_RA;
                S_DOT_RA: begin
                    r_cen   <= r_rdata;
                    r_state <= S_DOT_MUL;
                end
                S_DOT_MUL: begin
                    if (r_c == 2'd2) begin
                        r_state <= S_DOT_WAIT;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_DOT_RC;
                    end
                end
                S_DOT_WAIT: r_state <= S_DOT_CHK;
                S_DOT_CHK: begin
                    r_neg <= acc[ACC_W-1];
                    r_mag <= acc_mag[DT-1:0];
                    if (acc == '0) begin
                        r_beyond <= 1'b0;
                        r_state  <= S_SIDE;
                    end else if (|acc_mag[ACC_W-1:DT]) begin
                        r_beyond <= 1'b1;
                        r_state  <= S_SIDE;
                    end else begin
                        r_state <= S_SQ0;
                    end
                end
                S_SQ0:   r_state <= S_SQ1;
                S_SQ1:   r_state <= S_SQ2;
                S_SQ2:   r_state <= S_RL;
                S_RL:    r_state <= S_RH;
                S_RH:    r_state <= S_BWAIT;
                S_BWAIT: r_state <= S_BCHK;
                S_BCHK: begin
                    r_beyond <= !acc[ACC_W-1] && (acc != '0);
                    r_state  <= S_SIDE;
                end
                S_SIDE: begin
                    r_side[idx] <= new_side;
                    if (r_primed) begin
                        if (prev_side == SIDE_PLUS && new_side == SIDE_MINUS) begin
                            r_res <= r_camq[17:9];
                        end else if (prev_side == SIDE_MINUS && new_side == SIDE_PLUS) begin
                            r_res <= r_camq[8:0];
                        end
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_k <= 2'd0;
                    r_c <= 2'd0;
                    if ((r_i + CW'(1)) == r_cnt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_LEN_RD;
                    end
                end
                S_DONE: begin
                    r_primed <= 1'b1;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
